### rtl/qrs_pkg.sv
// Shared types, constants and a helper function for the quadratic root solver.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package qrs_pkg;

    // Default generics of the block.
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed widths of the result fields.
    localparam int OUT_W  = 36;
    localparam int KIND_W = 2;

    // Kind of roots reported with every result.
    typedef enum logic [KIND_W-1:0] {
        KIND_DISTINCT = 2'd0,
        KIND_EQUAL    = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    // Discriminant classification passed from the front end downstream.
    typedef struct packed {
        logic err;    // coefficient a is zero
        logic dneg;   // discriminant is negative
        logic dzero;  // discriminant is zero
    } disc_flags_t;

    // Width of the signed numerators fed to the divider lanes.
    function automatic int num_width(input int nb_w, input int root_w);
        int w;
        w = (nb_w > root_w + 1) ? nb_w : root_w + 1;
        return w + 1;
    endfunction

endpackage

`default_nettype wire

### rtl/qrs_disc.sv
// Front end: coefficient products and the exact discriminant, two register stages.
// Depends on qrs_pkg.
`default_nettype none

module qrs_disc
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     en,
    input  wire logic                                     in_valid,
    input  wire logic signed [COEF_WIDTH-1:0]             in_a,
    input  wire logic signed [COEF_WIDTH-1:0]             in_b,
    input  wire logic signed [COEF_WIDTH-1:0]             in_c,
    output logic                                          out_valid,
    output logic [2*COEF_WIDTH+1:0]                       out_dmag,
    output disc_flags_t                                   out_flags,
    output logic signed [COEF_WIDTH+FRAC_BITS:0]          out_nb,
    output logic signed [COEF_WIDTH:0]                    out_den
);

    localparam int W    = COEF_WIDTH;
    localparam int DW   = 2 * W + 2;
    localparam int NBW  = W + 1 + FRAC_BITS;

    // Stage one registers.
    logic                  v1_reg;
    logic [2*W-1:0]        acm_reg, acm_next;
    logic [2*W-1:0]        bsq_reg, bsq_next;
    logic                  mixed_reg, mixed_next;
    logic                  azero_reg, azero_next;
    logic signed [NBW-1:0] nb1_reg, nb1_next;
    logic signed [W:0]     den1_reg, den1_next;

    // Stage two registers.
    logic                  v2_reg;
    logic [DW-1:0]         dmag_reg, dmag_next;
    disc_flags_t           flags_reg, flags_next;
    logic signed [NBW-1:0] nb2_reg;
    logic signed [W:0]     den2_reg;

    logic [W-1:0]          mag_a, mag_b, mag_c;
    logic signed [NBW-1:0] nb_ext;
    logic [DW-1:0]         bw, four_ac;

    // Magnitudes, products and the scaled negated b.
    always_comb begin
        mag_a      = in_a[W-1] ? (~in_a + 1'b1) : in_a;
        mag_b      = in_b[W-1] ? (~in_b + 1'b1) : in_b;
        mag_c      = in_c[W-1] ? (~in_c + 1'b1) : in_c;
        acm_next   = mag_a * mag_c;
        bsq_next   = mag_b * mag_b;
        mixed_next = (in_a[W-1] != in_c[W-1]) && (in_c != '0);
        azero_next = (in_a == '0);
        nb_ext     = NBW'(in_b);
        nb1_next   = (-nb_ext) <<< FRAC_BITS;
        den1_next  = (W + 1)'(in_a) <<< 1;
    end

    // Discriminant magnitude and sign from b*b and 4*|a*c|.
    always_comb begin
        bw      = DW'(bsq_reg);
        four_ac = DW'(acm_reg) << 2;
        flags_next.err  = azero_reg;
        flags_next.dneg = 1'b0;
        if (mixed_reg) begin
            dmag_next = bw + four_ac;
        end else if (bw >= four_ac) begin
            dmag_next = bw - four_ac;
        end else begin
            dmag_next       = four_ac - bw;
            flags_next.dneg = 1'b1;
        end
        flags_next.dzero = (dmag_next == '0);
    end

    // Payload registers advance with the pipeline enable.
    always_ff @(posedge aclk) begin
        if (en) begin
            acm_reg   <= acm_next;
            bsq_reg   <= bsq_next;
            mixed_reg <= mixed_next;
            azero_reg <= azero_next;
            nb1_reg   <= nb1_next;
            den1_reg  <= den1_next;
            dmag_reg  <= dmag_next;
            flags_reg <= flags_next;
            nb2_reg   <= nb1_reg;
            den2_reg  <= den1_reg;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_dmag  = dmag_reg;
    assign out_flags = flags_reg;
    assign out_nb    = nb2_reg;
    assign out_den   = den2_reg;

endmodule

`default_nettype wire

### rtl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on qrs_pkg for defaults; carries an opaque sideband alongside.
`default_nettype none

module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int DMAG_W    = 2 * COEF_WIDTH_DEF + 2,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIDE_W    = 1
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     en,
    input  wire logic                                     in_valid,
    input  wire logic [DMAG_W-1:0]                        in_dmag,
    input  wire logic [SIDE_W-1:0]                        in_side,
    output logic                                          out_valid,
    output logic [(DMAG_W+2*FRAC_BITS+1)/2-1:0]           out_root,
    output logic [SIDE_W-1:0]                             out_side
);

    localparam int SQW  = (DMAG_W + 2 * FRAC_BITS + 1) / 2;
    localparam int RADW = 2 * SQW;
    localparam int RMW  = SQW + 3;

    typedef struct packed {
        logic [RMW-1:0]  rem;
        logic [SQW-1:0]  res;
        logic [RADW-1:0] rad;
    } stg_t;

    // One restoring step: bring down the next bit pair, try (res*4 + 1).
    function automatic stg_t sq_step(input stg_t cur);
        stg_t           nxt;
        logic [RMW-1:0] rem_s;
        logic [RMW-1:0] trial;
        nxt   = cur;
        rem_s = {cur.rem[RMW-3:0], cur.rad[RADW-1 -: 2]};
        trial = RMW'({cur.res, 2'b01});
        nxt.rad = cur.rad << 2;
        nxt.res = cur.res << 1;
        if (rem_s >= trial) begin
            nxt.rem    = rem_s - trial;
            nxt.res[0] = 1'b1;
        end else begin
            nxt.rem = rem_s;
        end
        return nxt;
    endfunction

    stg_t              stg_reg  [0:SQW-1];
    logic [SIDE_W-1:0] side_reg [0:SQW-1];
    logic              vld_reg  [0:SQW-1];
    stg_t              first_in;

    // Radicand is the discriminant magnitude scaled by 2^(2*FRAC_BITS).
    always_comb begin
        first_in.rem = '0;
        first_in.res = '0;
        first_in.rad = RADW'(in_dmag) << (2 * FRAC_BITS);
    end

    // Each stage resolves one root bit.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQW; k++) begin
                if (k == 0) begin
                    stg_reg[k]  <= sq_step(first_in);
                    side_reg[k] <= in_side;
                end else begin
                    stg_reg[k]  <= sq_step(stg_reg[k-1]);
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    // Valid bits shift with their stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SQW; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < SQW; k++) begin
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[SQW-1];
    assign out_root  = stg_reg[SQW-1].res;
    assign out_side  = side_reg[SQW-1];

endmodule

`default_nettype wire

### rtl/qrs_div.sv
// Two-lane pipelined restoring divider sharing one divisor 2a, one quotient bit
// per stage, preceded by a stage that forms the signed numerators. Uses qrs_pkg.
`default_nettype none

module qrs_div
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ROOT_W     = 33
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     en,
    input  wire logic                                     in_valid,
    input  wire logic [ROOT_W-1:0]                        in_root,
    input  wire logic signed [COEF_WIDTH+FRAC_BITS:0]     in_nb,
    input  wire logic signed [COEF_WIDTH:0]               in_den,
    input  wire disc_flags_t                              in_flags,
    output logic                                          out_valid,
    output kind_t                                         out_kind,
    output logic [num_width(COEF_WIDTH+FRAC_BITS+1, ROOT_W)-1:0] out_q1,
    output logic [num_width(COEF_WIDTH+FRAC_BITS+1, ROOT_W)-1:0] out_q2,
    output logic                                          out_neg1,
    output logic                                          out_neg2
);

    localparam int W    = COEF_WIDTH;
    localparam int NBW  = W + 1 + FRAC_BITS;
    localparam int NUMW = num_width(NBW, ROOT_W);
    localparam int RMW  = W + 2;

    typedef struct packed {
        logic [RMW-1:0]  rem;
        logic [NUMW-1:0] num;
    } lane_t;

    // One restoring step; quotient bits replace numerator bits from the right.
    function automatic lane_t dv_step(input lane_t cur, input logic [W:0] d);
        lane_t          nxt;
        logic [RMW-1:0] r;
        r       = {cur.rem[RMW-2:0], cur.num[NUMW-1]};
        nxt.num = cur.num << 1;
        if (r >= RMW'(d)) begin
            nxt.rem    = r - RMW'(d);
            nxt.num[0] = 1'b1;
        end else begin
            nxt.rem = r;
        end
        return nxt;
    endfunction

    // Prep stage signals.
    kind_t                  kind_c;
    logic signed [NUMW-1:0] s_ext, nb_ext, n1, n2;
    logic                   p_vld_reg;
    lane_t                  p_l1_reg, p_l2_reg, p_l1_next, p_l2_next;
    logic [W:0]             p_d_reg, p_d_next;
    logic                   p_neg1_reg, p_neg2_reg, p_neg1_next, p_neg2_next;
    kind_t                  p_kind_reg;

    // Iteration stages.
    lane_t      l1_reg   [0:NUMW-1];
    lane_t      l2_reg   [0:NUMW-1];
    logic [W:0] d_reg    [0:NUMW-1];
    logic       neg1_reg [0:NUMW-1];
    logic       neg2_reg [0:NUMW-1];
    kind_t      kind_reg [0:NUMW-1];
    logic       vld_reg  [0:NUMW-1];

    // Classify the roots and pick the two numerators.
    always_comb begin
        if (in_flags.err) begin
            kind_c = KIND_ERROR;
        end else if (in_flags.dzero) begin
            kind_c = KIND_EQUAL;
        end else if (in_flags.dneg) begin
            kind_c = KIND_COMPLEX;
        end else begin
            kind_c = KIND_DISTINCT;
        end
        s_ext  = $signed(NUMW'(in_root));
        nb_ext = NUMW'(in_nb);
        n1 = (kind_c == KIND_DISTINCT) ? (nb_ext + s_ext) : nb_ext;
        if (kind_c == KIND_DISTINCT) begin
            n2 = nb_ext - s_ext;
        end else if (kind_c == KIND_COMPLEX) begin
            n2 = s_ext;
        end else begin
            n2 = nb_ext;
        end
        p_l1_next.rem = '0;
        p_l2_next.rem = '0;
        p_l1_next.num = n1[NUMW-1] ? NUMW'(-n1) : NUMW'(n1);
        p_l2_next.num = n2[NUMW-1] ? NUMW'(-n2) : NUMW'(n2);
        p_d_next      = in_den[W] ? (W + 1)'(-in_den) : (W + 1)'(in_den);
        p_neg1_next   = n1[NUMW-1] ^ in_den[W];
        p_neg2_next   = n2[NUMW-1] ^ in_den[W];
    end

    // Prep and iteration payload registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_l1_reg   <= p_l1_next;
            p_l2_reg   <= p_l2_next;
            p_d_reg    <= p_d_next;
            p_neg1_reg <= p_neg1_next;
            p_neg2_reg <= p_neg2_next;
            p_kind_reg <= kind_c;
            for (int k = 0; k < NUMW; k++) begin
                if (k == 0) begin
                    l1_reg[k]   <= dv_step(p_l1_reg, p_d_reg);
                    l2_reg[k]   <= dv_step(p_l2_reg, p_d_reg);
                    d_reg[k]    <= p_d_reg;
                    neg1_reg[k] <= p_neg1_reg;
                    neg2_reg[k] <= p_neg2_reg;
                    kind_reg[k] <= p_kind_reg;
                end else begin
                    l1_reg[k]   <= dv_step(l1_reg[k-1], d_reg[k-1]);
                    l2_reg[k]   <= dv_step(l2_reg[k-1], d_reg[k-1]);
                    d_reg[k]    <= d_reg[k-1];
                    neg1_reg[k] <= neg1_reg[k-1];
                    neg2_reg[k] <= neg2_reg[k-1];
                    kind_reg[k] <= kind_reg[k-1];
                end
            end
        end
    end

    // Valid bits shift with their stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
            for (int k = 0; k < NUMW; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            p_vld_reg <= in_valid;
            for (int k = 0; k < NUMW; k++) begin
                vld_reg[k] <= (k == 0) ? p_vld_reg : vld_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NUMW-1];
    assign out_kind  = kind_reg[NUMW-1];
    assign out_q1    = l1_reg[NUMW-1].num;
    assign out_q2    = l2_reg[NUMW-1].num;
    assign out_neg1  = neg1_reg[NUMW-1];
    assign out_neg2  = neg2_reg[NUMW-1];

endmodule

`default_nettype wire

### rtl/quadratic_root_solver_unit.sv
// Pipeline: two front-end stages, one square-root stage per root bit, a divider prep
// stage, one divider stage per quotient bit and the output register.
// Throughput: one transaction per cycle; the whole pipeline advances whenever the
// output register is empty or being taken. Reset (aresetn, synchronous, active
// low) clears all valid bits; payload registers are not reset.
`default_nettype none

module quadratic_root_solver_unit
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COEF_WIDTH-1:0]  s_coef_a,
    input  wire logic signed [COEF_WIDTH-1:0]  s_coef_b,
    input  wire logic signed [COEF_WIDTH-1:0]  s_coef_c,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [KIND_W-1:0]                  m_root_kind,
    output logic signed [OUT_W-1:0]            m_first_value,
    output logic signed [OUT_W-1:0]            m_second_value
);

    localparam int W      = COEF_WIDTH;
    localparam int DMAG_W = 2 * W + 2;
    localparam int NBW    = W + 1 + FRAC_BITS;
    localparam int ROOT_W = (DMAG_W + 2 * FRAC_BITS + 1) / 2;
    localparam int SIDE_W = $bits(disc_flags_t) + NBW + W + 1;
    localparam int NUMW   = num_width(NBW, ROOT_W);
    localparam int RW     = NUMW + 1;
    localparam int XW     = (RW > OUT_W) ? RW : OUT_W;
    localparam logic signed [XW-1:0] SAT_MAX = XW'({1'b0, {(OUT_W - 1){1'b1}}});
    localparam logic signed [XW-1:0] SAT_MIN = -SAT_MAX - 1;

    logic                   en;
    logic                   d_valid;
    logic [DMAG_W-1:0]      d_dmag;
    disc_flags_t            d_flags;
    logic signed [NBW-1:0]  d_nb;
    logic signed [W:0]      d_den;
    logic                   q_valid;
    logic [ROOT_W-1:0]      q_root;
    logic [SIDE_W-1:0]      q_side;
    disc_flags_t            q_flags;
    logic signed [NBW-1:0]  q_nb;
    logic signed [W:0]      q_den;
    logic                   v_valid;
    kind_t                  v_kind;
    logic [NUMW-1:0]        v_q1, v_q2;
    logic                   v_neg1, v_neg2;

    logic                   m_valid_reg;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic signed [OUT_W-1:0] first_reg, first_next;
    logic signed [OUT_W-1:0] second_reg, second_next;

    // The pipeline moves whenever the output register can take a transaction.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    qrs_disc #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_disc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_a      (s_coef_a),
        .in_b      (s_coef_b),
        .in_c      (s_coef_c),
        .out_valid (d_valid),
        .out_dmag  (d_dmag),
        .out_flags (d_flags),
        .out_nb    (d_nb),
        .out_den   (d_den)
    );

    qrs_sqrt #(
        .DMAG_W    (DMAG_W),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_dmag   (d_dmag),
        .in_side   ({d_flags, d_nb, d_den}),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_side)
    );

    assign {q_flags, q_nb, q_den} = q_side;

    qrs_div #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ROOT_W     (ROOT_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_root   (q_root),
        .in_nb     (q_nb),
        .in_den    (q_den),
        .in_flags  (q_flags),
        .out_valid (v_valid),
        .out_kind  (v_kind),
        .out_q1    (v_q1),
        .out_q2    (v_q2),
        .out_neg1  (v_neg1),
        .out_neg2  (v_neg2)
    );

    // Apply the quotient sign and clamp to the 36-bit result range.
    function automatic logic signed [OUT_W-1:0] finish(input logic [NUMW-1:0] q,
                                                       input logic neg);
        logic signed [RW-1:0] v;
        logic signed [XW-1:0] x;
        v = $signed({1'b0, q});
        if (neg) begin
            v = -v;
        end
        x = XW'(v);
        if (x > SAT_MAX) begin
            x = SAT_MAX;
        end else if (x < SAT_MIN) begin
            x = SAT_MIN;
        end
        return OUT_W'(x);
    endfunction

    // Result formatting; a zero a forces both values to zero.
    always_comb begin
        kind_next = v_kind;
        if (v_kind == KIND_ERROR) begin
            first_next  = '0;
            second_next = '0;
        end else begin
            first_next  = finish(v_q1, v_neg1);
            second_next = finish(v_q2, v_neg2);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind_reg   <= kind_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_valid;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_root_kind    = kind_reg;
    assign m_first_value  = first_reg;
    assign m_second_value = second_reg;

endmodule

`default_nettype wire

### rtl/qrs_checker.sv
// Port-level checks for quadratic_root_solver_unit, attached with a bind.
// Depends on qrs_pkg and on the top level's port list.
`default_nettype none

module qrs_checker
    import qrs_pkg::*;
(
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [KIND_W-1:0]             m_root_kind,
    input wire logic signed [OUT_W-1:0]       m_first_value,
    input wire logic signed [OUT_W-1:0]       m_second_value
);

    // A stalled result transaction holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_root_kind)
            && $stable(m_first_value) && $stable(m_second_value))
        else $error("result changed while stalled");

    // An empty output register never blocks the input side.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // The error kind always carries zero values.
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_root_kind == KIND_ERROR |-> m_first_value == '0
            && m_second_value == '0)
        else $error("error result with nonzero values");

    // A repeated root shows the same value in both fields.
    a_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_root_kind == KIND_EQUAL |-> m_first_value == m_second_value)
        else $error("repeated root fields differ");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_root_kind    (m_root_kind),
    .m_first_value  (m_first_value),
    .m_second_value (m_second_value)
);

`default_nettype wire
